// ===== hw/rtl/prih_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prih_pkg
// Shared constants of the per-run interval histogram core.
// ----------------------------------------------------------------------------
package prih_pkg;

	localparam int DEF_RUN_SLOTS = 16;
	localparam int DEF_MAX_BINS  = 128;
	localparam int STREAMS       = 3;

	localparam logic [1:0] FUNC_EVENT = 2'd0;
	localparam logic [1:0] FUNC_RDBIN = 2'd1;
	localparam logic [1:0] FUNC_RDQ   = 2'd2;

	localparam logic [1:0] STREAM_ALL    = 2'd0;
	localparam logic [1:0] STREAM_SINGLE = 2'd1;
	localparam logic [1:0] STREAM_BUNDLE = 2'd2;

	localparam logic CFG_BIN_WIDTH = 1'b0;
	localparam logic CFG_BINS_USED = 1'b1;

	localparam logic [29:0] BIN_WIDTH_RST = 30'd50000000;
	localparam logic [7:0]  BINS_USED_RST = 8'd100;

	localparam logic signed [63:0] NS_PER_SEC = 64'sd1000000000;

endpackage

// ===== hw/rtl/per_run_interval_histogram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_run_interval_histogram_core
// Per-run inter-arrival histograms over three streams with chi2 statistics.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// command   in         start & !busy        func .. bin_pick
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
// result    out        done (one cycle)     bin_count .. filed_bin
//
// An event that opens a run passes ST_SQ, ST_ACC and ST_TRD. One that files n
// intervals (n = 1 or 2) passes ST_SQ and ST_ACC, then for each interval ST_TRD, ST_TMUL,
// ST_TADD, ST_TCMP, B = clog2(MAX_BINS+1) divider steps in ST_DIV, which are skipped
// for underflow and overflow, ST_CRD and ST_CWR. A bin read passes ST_SQ, ST_RRD and
// ST_RWT, a statistics read or any other word only ST_SQ; done rises as busy falls.
// The count memory has one port pair, so each filed interval is a read and a write-back.
// After reset a clearing pass zeroes all RUN_SLOTS*3*(MAX_BINS+2) counts; busy stays high.
// The receiver cannot stall: each result shows for one cycle under done.
module per_run_interval_histogram_core #(
	parameter int RUN_SLOTS = prih_pkg::DEF_RUN_SLOTS,
	parameter int MAX_BINS  = prih_pkg::DEF_MAX_BINS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [3:0]  run_slot,
	input  logic [31:0] stamp_sec,
	input  logic [29:0] stamp_nsec,
	input  logic [15:0] track_total,
	input  logic        fit_ok,
	input  logic [31:0] fit_quality,
	input  logic [1:0]  stream_pick,
	input  logic [7:0]  bin_pick,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [29:0] cfg_data,
	output logic        done,
	output logic [31:0] bin_count,
	output logic [63:0] quality_sum,
	output logic [63:0] quality_square_sum,
	output logic [31:0] quality_entries,
	output logic        run_started,
	output logic [7:0]  filed_bin
);
	import prih_pkg::*;

	localparam int BINS  = MAX_BINS + 2;
	localparam int NK    = RUN_SLOTS * STREAMS;
	localparam int CD    = NK * BINS;
	localparam int CAW   = $clog2(CD);
	localparam int SKW   = (NK > 1) ? $clog2(NK) : 1;
	localparam int SLW   = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int BW    = $clog2(BINS);
	localparam int UW    = $clog2(MAX_BINS + 1);
	localparam int DIW   = $clog2(UW);
	localparam int RW    = UW + 30;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_TRD   = 4'd4;
	localparam logic [3:0] ST_TMUL  = 4'd5;
	localparam logic [3:0] ST_TADD  = 4'd6;
	localparam logic [3:0] ST_TCMP  = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_CRD   = 4'd9;
	localparam logic [3:0] ST_CWR   = 4'd10;
	localparam logic [3:0] ST_RRD   = 4'd11;
	localparam logic [3:0] ST_RWT   = 4'd12;

	localparam logic [BW-1:0] BIN_UNDER = BW'(MAX_BINS);
	localparam logic [BW-1:0] BIN_OVER  = BW'(MAX_BINS + 1);

	logic [3:0]     state_q;
	logic [CAW-1:0] clr_q;
	logic [29:0]    width_q;
	logic [7:0]     used_q;

	logic [1:0]  func_q;
	logic [3:0]  slot_q;
	logic [31:0] sec_q;
	logic [29:0] nsec_q;
	logic [15:0] trk_q;
	logic        ok_q;
	logic [31:0] chi_q;
	logic [1:0]  spick_q;
	logic [7:0]  bpick_q;
	logic [1:0]  stream_q;

	logic [NK-1:0] seen_q;
	logic [63:0]   qsum_q [RUN_SLOTS];
	logic [63:0]   qsq_q  [RUN_SLOTS];
	logic [31:0]   qcnt_q [RUN_SLOTS];
	logic [63:0]   sq_q;

	logic [61:0]   tm_mem [NK];
	logic [61:0]   tm_rd_q;
	logic [31:0]   cnt_mem [CD];
	logic [31:0]   cnt_rd_q;
	logic [CAW-1:0] cnt_addr_q;

	logic signed [63:0] prod_q;
	logic signed [30:0] dns_q;
	logic signed [63:0] d_q;
	logic [RW-1:0]      limit_q;
	logic [RW-1:0]      rem_q;
	logic [UW-1:0]      quot_q;
	logic [DIW-1:0]     div_i_q;
	logic [BW-1:0]      bin_q;

	logic           accept;
	logic           slot_ok;
	logic [SKW-1:0] k;
	logic [SLW-1:0] sl;
	logic [29:0]    weff;
	logic [UW-1:0]  ueff;
	logic [CAW-1:0] ev_addr;
	logic [CAW-1:0] rd_addr;
	logic           rd_ok;
	logic           cnt_we;
	logic [CAW-1:0] cnt_wa;
	logic [31:0]    cnt_wd;
	logic [CAW-1:0] cnt_ra;
	logic [RW-1:0]  dsub;
	logic signed [32:0] dsec;
	logic [64:0]    sum_n;
	logic [64:0]    sqs_n;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign slot_ok   = (32'(slot_q) < 32'(RUN_SLOTS));
	assign sl        = SLW'(slot_q);
	assign k         = SKW'(32'(slot_q) * STREAMS + 32'(stream_q));
	assign weff      = (width_q == 30'd0) ? 30'd1 : width_q;
	assign ueff      = (32'(used_q) > 32'(MAX_BINS)) ? UW'(MAX_BINS) : UW'(used_q);
	assign ev_addr   = CAW'(32'(k) * BINS + 32'(bin_q));
	assign rd_ok     = (spick_q != 2'd3) && (32'(bpick_q) < 32'(BINS));
	assign rd_addr   = CAW'((32'(slot_q) * STREAMS + 32'(spick_q)) * BINS + 32'(bpick_q));
	assign dsub      = RW'(weff) << div_i_q;
	assign dsec      = $signed({1'b0, sec_q}) - $signed({1'b0, tm_rd_q[61:30]});
	assign sum_n     = {1'b0, qsum_q[sl]} + {33'd0, chi_q};
	assign sqs_n     = {1'b0, qsq_q[sl]} + {17'd0, sq_q[63:16]};

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = cnt_addr_q;
		cnt_wd = (cnt_rd_q == 32'hFFFF_FFFF) ? cnt_rd_q : cnt_rd_q + 32'd1;
		cnt_ra = ev_addr;
		if (state_q == ST_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
			cnt_wd = 32'd0;
		end else if (state_q == ST_CWR) begin
			cnt_we = 1'b1;
		end
		if (state_q == ST_RRD) begin
			cnt_ra = rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TRD) begin
			tm_mem[k] <= {sec_q, nsec_q};
		end
		tm_rd_q <= tm_mem[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= BIN_WIDTH_RST;
			used_q  <= BINS_USED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BIN_WIDTH: width_q <= cfg_data;
				CFG_BINS_USED: used_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			slot_q   <= run_slot;
			sec_q    <= stamp_sec;
			nsec_q   <= stamp_nsec;
			trk_q    <= track_total;
			ok_q     <= fit_ok;
			chi_q    <= fit_quality;
			spick_q  <= stream_pick;
			bpick_q  <= bin_pick;
		end
		if (state_q == ST_SQ) begin
			sq_q <= 64'(chi_q) * 64'(chi_q);
		end
		if (state_q == ST_TMUL) begin
			prod_q  <= 64'(dsec) * NS_PER_SEC;
			dns_q   <= $signed({1'b0, nsec_q}) - $signed({1'b0, tm_rd_q[29:0]});
			limit_q <= RW'(ueff) * RW'(weff);
		end
		if (state_q == ST_TADD) begin
			d_q <= prod_q + 64'(dns_q);
		end
		if (state_q == ST_CRD) begin
			cnt_addr_q <= ev_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_CLEAR;
			clr_q              <= '0;
			seen_q             <= '0;
			done               <= 1'b0;
			stream_q           <= STREAM_ALL;
			rem_q              <= '0;
			quot_q             <= '0;
			div_i_q            <= '0;
			bin_q              <= '0;
			bin_count          <= '0;
			quality_sum        <= '0;
			quality_square_sum <= '0;
			quality_entries    <= '0;
			run_started        <= 1'b0;
			filed_bin          <= '0;
			for (int i = 0; i < RUN_SLOTS; i++) begin
				qsum_q[i] <= '0;
				qsq_q[i]  <= '0;
				qcnt_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CD - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						stream_q           <= STREAM_ALL;
						bin_count          <= '0;
						quality_sum        <= '0;
						quality_square_sum <= '0;
						quality_entries    <= '0;
						run_started        <= 1'b0;
						filed_bin          <= '0;
						state_q            <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (!slot_ok) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						case (func_q)
							FUNC_EVENT: state_q <= ST_ACC;
							FUNC_RDBIN: state_q <= ST_RRD;
							FUNC_RDQ: begin
								quality_sum        <= qsum_q[sl];
								quality_square_sum <= qsq_q[sl];
								quality_entries    <= qcnt_q[sl];
								done               <= 1'b1;
								state_q            <= ST_IDLE;
							end
							default: begin
								done    <= 1'b1;
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ACC: begin
					if (ok_q) begin
						qsum_q[sl] <= sum_n[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_n[63:0];
						qsq_q[sl]  <= sqs_n[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sqs_n[63:0];
						if (qcnt_q[sl] != 32'hFFFF_FFFF) begin
							qcnt_q[sl] <= qcnt_q[sl] + 32'd1;
						end
					end
					state_q <= ST_TRD;
				end
				ST_TRD: begin
					if (!seen_q[k]) begin
						seen_q[k] <= 1'b1;
						if (stream_q == STREAM_ALL) begin
							run_started <= 1'b1;
						end
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: state_q <= ST_TADD;
				ST_TADD: state_q <= ST_TCMP;
				ST_TCMP: begin
					if (d_q < 0) begin
						bin_q   <= BIN_UNDER;
						state_q <= ST_CRD;
					end else if (d_q >= $signed({1'b0, 63'(limit_q)})) begin
						bin_q   <= BIN_OVER;
						state_q <= ST_CRD;
					end else begin
						rem_q   <= d_q[RW-1:0];
						quot_q  <= '0;
						div_i_q <= DIW'(UW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_q >= dsub) begin
						rem_q           <= rem_q - dsub;
						quot_q[div_i_q] <= 1'b1;
					end
					if (div_i_q == '0) begin
						bin_q   <= BW'({quot_q[UW-1:1], (rem_q >= dsub) | quot_q[0]});
						state_q <= ST_CRD;
					end else begin
						div_i_q <= div_i_q - 1'b1;
					end
				end
				ST_CRD: begin
					if (stream_q == STREAM_ALL) begin
						filed_bin <= 8'(bin_q);
					end
					state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (stream_q == STREAM_ALL && trk_q != 16'd0) begin
						stream_q <= (trk_q == 16'd1) ? STREAM_SINGLE : STREAM_BUNDLE;
						state_q  <= ST_TRD;
					end else begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RRD: state_q <= ST_RWT;
				ST_RWT: begin
					bin_count <= rd_ok ? cnt_rd_q : 32'd0;
					done      <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) != ST_IDLE && $past(state_q) != ST_CLEAR))
		else $error("result strobe without work in progress");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (busy && !done))
		else $error("activity during clearing pass");
	a_write_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CWR) |-> seen_q[k])
		else $error("count write for a stream with no previous time");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (32'(div_i_q) < UW))
		else $error("divider step out of range");

endmodule

// ===== test/tb_per_run_interval_histogram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_run_interval_histogram_core
// Self-checking bench for the per-run interval histogram core. Command words
// are queued by a stimulus process and driven by a clocked driver with random
// gaps. A predictor keeps its own run table, histograms and chi2 statistics
// and computes the expected result of every accepted word. A monitor compares
// each result with the oldest expectation. Bin settings are changed between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_per_run_interval_histogram_core;
	import prih_pkg::*;

	localparam logic [1:0] FUNC_NONE   = 2'd3;
	localparam logic [1:0] STREAM_NONE = 2'd3;
	localparam int UNDER_BIN = DEF_MAX_BINS;
	localparam int OVER_BIN  = DEF_MAX_BINS + 1;
	localparam int BIN_SLOTS = DEF_MAX_BINS + 2;
	localparam int KEYS      = DEF_RUN_SLOTS * STREAMS;
	localparam longint NS    = 64'd1000000000;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [15:0] tracks;
		logic        ok;
		logic [31:0] chi;
		logic [1:0]  stream;
		logic [7:0]  binp;
	} cmd_t;

	typedef struct packed {
		logic [31:0] count;
		logic [63:0] qsum;
		logic [63:0] qsq;
		logic [31:0] qent;
		logic        started;
		logic [7:0]  fbin;
	} res_t;

	logic clk = 0, arst_n = 0, start = 0, busy, cfg_valid = 0, cfg_ready, cfg_index = 0;
	logic [29:0] cfg_data = '0;
	logic done, run_started;
	logic [1:0] func = '0, stream_pick = '0;
	logic [3:0] run_slot = '0;
	logic [31:0] stamp_sec = '0, fit_quality = '0, bin_count, quality_entries;
	logic [29:0] stamp_nsec = '0;
	logic [15:0] track_total = '0;
	logic fit_ok = 0;
	logic [7:0] bin_pick = '0, filed_bin;
	logic [63:0] quality_sum, quality_square_sum;

	per_run_interval_histogram_core uut (.*);

	initial forever #2 clk = ~clk;

	cmd_t pending[$];
	res_t expected[$];
	int errors = 0, accepted = 0;
	logic took = 0;

	// Predictor state.
	logic [29:0] width_cfg = BIN_WIDTH_RST;
	logic [7:0]  used_cfg  = BINS_USED_RST;
	bit          seen[KEYS];
	logic [31:0] last_s[KEYS];
	logic [29:0] last_ns[KEYS];
	logic [31:0] hist[KEYS][BIN_SLOTS];
	logic [63:0] chi_sum[DEF_RUN_SLOTS], chi_sq[DEF_RUN_SLOTS];
	logic [31:0] chi_cnt[DEF_RUN_SLOTS];
	longint now_ns[DEF_RUN_SLOTS];

	initial begin
		for (int k = 0; k < KEYS; k++) begin
			seen[k] = 0;
			for (int b = 0; b < BIN_SLOTS; b++) hist[k][b] = '0;
		end
		for (int s = 0; s < DEF_RUN_SLOTS; s++) begin
			chi_sum[s] = '0; chi_sq[s] = '0; chi_cnt[s] = '0;
			now_ns[s] = longint'($urandom_range(0, 1 << 30)) * NS;
		end
	end

	function automatic int interval_bin(logic [31:0] s, logic [29:0] n,
			logic [31:0] ps, logic [29:0] pn);
		longint d;
		longint unsigned w, u, q;
		d = (longint'(s) - longint'(ps)) * NS + (longint'(n) - longint'(pn));
		w = (width_cfg == 0) ? 64'd1 : 64'(width_cfg);
		u = (used_cfg > DEF_MAX_BINS) ? 64'(DEF_MAX_BINS) : 64'(used_cfg);
		if (d < 0) return UNDER_BIN;
		q = longint'(d) / w;
		if (q >= u) return OVER_BIN;
		return int'(q);
	endfunction

	function automatic int file_interval(int k, logic [31:0] s, logic [29:0] n);
		int b;
		if (!seen[k]) begin
			seen[k] = 1; last_s[k] = s; last_ns[k] = n;
			return -1;
		end
		b = interval_bin(s, n, last_s[k], last_ns[k]);
		if (hist[k][b] != '1) hist[k][b]++;
		last_s[k] = s; last_ns[k] = n;
		return b;
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [64:0] t;
		t = a + b;
		return t[64] ? '1 : t[63:0];
	endfunction

	function automatic res_t predict_result(cmd_t c);
		res_t r;
		int b, k;
		logic [63:0] wide;
		r = '0;
		k = c.slot * STREAMS;
		case (c.func)
			FUNC_EVENT: begin
				if (c.ok) begin
					wide = {32'd0, c.chi};
					chi_sum[c.slot] = sat_add(chi_sum[c.slot], wide);
					chi_sq[c.slot] = sat_add(chi_sq[c.slot], (wide * wide) >> 16);
					if (chi_cnt[c.slot] != '1) chi_cnt[c.slot]++;
				end
				b = file_interval(k + STREAM_ALL, c.sec, c.nsec);
				if (b < 0) r.started = 1;
				else begin
					r.fbin = b[7:0];
					if (c.tracks == 1) void'(file_interval(k + STREAM_SINGLE, c.sec, c.nsec));
					else if (c.tracks > 1) void'(file_interval(k + STREAM_BUNDLE, c.sec, c.nsec));
				end
			end
			FUNC_RDBIN: if (c.stream != STREAM_NONE && c.binp < BIN_SLOTS)
				r.count = hist[k + c.stream][c.binp];
			FUNC_RDQ: begin
				r.qsum = chi_sum[c.slot]; r.qsq = chi_sq[c.slot]; r.qent = chi_cnt[c.slot];
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: a word stays on the ports until it is accepted.
	always @(negedge clk) begin
		if (!(start && !took)) begin
			if (pending.size() != 0 &&
					((accepted >= 300 && accepted < 450) || $urandom_range(0, 99) >= 20)) begin
				cmd_t c;
				c = pending.pop_front();
				func <= c.func; run_slot <= c.slot; stamp_sec <= c.sec;
				stamp_nsec <= c.nsec; track_total <= c.tracks; fit_ok <= c.ok;
				fit_quality <= c.chi; stream_pick <= c.stream; bin_pick <= c.binp;
				start <= 1;
			end else
				start <= 0;
		end
	end

	// Monitor: prediction on acceptance, comparison on done.
	always @(posedge clk) begin
		res_t got, want;
		took <= start && !busy;
		if (start && !busy) begin
			expected.push_back(predict_result({func, run_slot, stamp_sec, stamp_nsec,
				track_total, fit_ok, fit_quality, stream_pick, bin_pick}));
			accepted++;
		end
		if (done) begin
			got = {bin_count, quality_sum, quality_square_sum, quality_entries,
				run_started, filed_bin};
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result word %h", got);
			end else begin
				want = expected.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected %h, got %h", want, got);
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending.size() != 0 || expected.size() != 0 || start || busy)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [29:0] value);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_BIN_WIDTH) width_cfg = value;
		else used_cfg = value[7:0];
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int r;
		longint unsigned span, delta;
		longint t;
		c = '0;
		c.slot = 4'($urandom_range(0, 15));
		c.ok = 1'($urandom_range(0, 1));
		c.chi = $urandom;
		r = $urandom_range(0, 3);
		c.tracks = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : 16'($urandom_range(2, 65535));
		r = $urandom_range(0, 99);
		if (r < 55) begin
			c.func = FUNC_EVENT;
			span = longint'((width_cfg == 0) ? 1 : width_cfg) *
				((used_cfg == 0) ? 1 : ((used_cfg > 128) ? 130 : used_cfg + 2));
			delta = {$urandom, $urandom} % span;
			t = now_ns[c.slot];
			if ($urandom_range(0, 9) == 0 && t > longint'(delta)) t = t - delta;
			else t = t + delta;
			now_ns[c.slot] = t;
			c.sec = 32'(t / NS); c.nsec = 30'(t % NS);
		end else if (r < 60) begin
			c.func = FUNC_EVENT;
			c.sec = $urandom; c.nsec = 30'($urandom_range(0, 999999999));
		end else if (r < 88) begin
			c.func = FUNC_RDBIN;
			c.stream = ($urandom_range(0, 19) == 0) ? STREAM_NONE : 2'($urandom_range(0, 2));
			r = $urandom_range(0, 9);
			c.binp = (r == 0) ? 8'($urandom) : (r < 3) ? 8'($urandom_range(128, 129))
				: 8'($urandom_range(0, (used_cfg > 0 && used_cfg < 128) ? used_cfg : 127));
		end else if (r < 96) c.func = FUNC_RDQ;
		else begin
			c.func = FUNC_NONE;
			c.stream = 2'($urandom); c.binp = 8'($urandom); c.sec = $urandom;
		end
		return c;
	endfunction

	function automatic cmd_t event_word(logic [3:0] s, logic [31:0] sec, logic [29:0] ns,
			logic [15:0] tr, logic ok, logic [31:0] chi);
		cmd_t c;
		c = '0;
		c.func = FUNC_EVENT; c.slot = s; c.sec = sec; c.nsec = ns;
		c.tracks = tr; c.ok = ok; c.chi = chi;
		return c;
	endfunction

	function automatic cmd_t read_word(logic [1:0] f, logic [3:0] s, logic [1:0] st,
			logic [7:0] b);
		cmd_t c;
		c = '0;
		c.func = f; c.slot = s; c.stream = st; c.binp = b;
		return c;
	endfunction

	initial begin
		logic [29:0] widths[6];
		logic [29:0] useds[6];
		widths = '{30'd50000000, 30'd1000, 30'd0, 30'h3FFFFFFF, 30'd7, 30'd50000000};
		useds = '{30'd100, 30'h3FFFFF80, 30'd0, 30'h2AAAAFF, 30'd1, 30'd100};
		repeat (2) @(negedge clk);
		arst_n = 1;

		// Directed words: first event of a run, class streams, extremes.
		pending.push_back(event_word(4'd15, 32'd0, 30'd0, 16'd1, 1'b1, 32'hFFFFFFFF));
		pending.push_back(event_word(4'd15, 32'd0, 30'd999999999, 16'd1, 1'b1, 32'hFFFFFFFF));
		pending.push_back(event_word(4'd15, 32'd1, 30'd0, 16'd1, 1'b0, 32'd5));
		pending.push_back(event_word(4'd15, 32'd4, 30'd0, 16'hFFFF, 1'b1, 32'd0));
		pending.push_back(event_word(4'd15, 32'd5, 30'd0, 16'hFFFF, 1'b1, 32'h00010000));
		pending.push_back(event_word(4'd15, 32'd3, 30'd0, 16'd0, 1'b1, 32'd1));
		pending.push_back(event_word(4'd15, 32'hFFFFFFFF, 30'd999999999, 16'd2, 1'b0, 32'd0));
		pending.push_back(event_word(4'd15, 32'd0, 30'd0, 16'd1, 1'b0, 32'd0));
		pending.push_back(event_word(4'd0, 32'd100, 30'd0, 16'd0, 1'b1, 32'd7));
		pending.push_back(event_word(4'd0, 32'd100, 30'd49999999, 16'd0, 1'b1, 32'd7));
		pending.push_back(event_word(4'd0, 32'd100, 30'd50000000, 16'd1, 1'b1, 32'd7));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_ALL, 8'd0));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_ALL, 8'(UNDER_BIN)));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_ALL, 8'(OVER_BIN)));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_SINGLE, 8'd20));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_BUNDLE, 8'd20));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_NONE, 8'd0));
		pending.push_back(read_word(FUNC_RDBIN, 4'd15, STREAM_ALL, 8'hFF));
		pending.push_back(read_word(FUNC_RDQ, 4'd15, STREAM_ALL, 8'd0));
		pending.push_back(read_word(FUNC_RDQ, 4'd0, STREAM_ALL, 8'd0));
		pending.push_back(read_word(FUNC_NONE, 4'd15, STREAM_NONE, 8'hFF));

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			if (p > 0) begin
				write_reg(CFG_BIN_WIDTH, widths[p]);
				write_reg(CFG_BINS_USED, useds[p]);
			end
			for (int i = 0; i < ((p == 0) ? 100 : 130); i++)
				pending.push_back(random_cmd());
		end
		wait_idle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("Verification failed");
		$finish;
	end

endmodule
